[rtl/core/dist_pkg.sv]
// ----------------------------------------------------------------------------
// dist_pkg: shared types for the debounced ignition session tracker
// Command codes, request and result payloads, and the tracker state record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dist_pkg;

  localparam logic [1:0] CMD_SAMPLE  = 2'd0;
  localparam logic [1:0] CMD_TAKE    = 2'd1;
  localparam logic [1:0] CMD_STARTED = 2'd2;
  localparam logic [1:0] CMD_STOPPED = 2'd3;

  localparam logic [15:0] SETTLE_MS_RESET = 16'd500;

  // Register indexes on the configuration port.
  localparam logic REG_SETTLE_MS = 1'b0;

  typedef struct packed {
    logic [1:0]  command;
    logic        ignition;
    logic [63:0] timestamp_ms;
  } dist_in_t;

  typedef struct packed {
    logic        start_granted;
    logic        stable_level;
    logic        stable_valid;
    logic        session_active;
    logic [31:0] session_number;
  } dist_out_t;

  typedef struct packed {
    logic        active;
    logic        raw_last;
    logic        raw_seen;
    logic        deb_level;
    logic        deb_known;
    logic        start_pending;
    logic [63:0] edge_time;
    logic [31:0] session_count;
  } dist_state_t;

endpackage

[rtl/core/dist_step.sv]
// ----------------------------------------------------------------------------
// dist_step: next-state and status logic for one request
// Debounce compare, start-request bookkeeping and session numbering.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dist_step (
  input  dist_pkg::dist_state_t state,
  input  dist_pkg::dist_in_t    item,
  input  logic [15:0]           settle_ms,
  output dist_pkg::dist_state_t state_nxt,
  output dist_pkg::dist_out_t   result
);

  logic        changed;
  logic [64:0] diff;
  logic        too_early;
  logic        settled;
  logic        granted;

  assign changed = item.ignition != state.raw_last;
  assign diff    = {1'b0, item.timestamp_ms} - {1'b0, state.edge_time};

  // A raw change restarts the timer, so the elapsed time is zero then.
  assign too_early = !changed && diff[64];
  assign settled   = changed ? (settle_ms == 16'd0)
                             : (!diff[64] && ((diff[63:16] != 48'd0) ||
                                              (diff[15:0] >= settle_ms)));

  always_comb begin
    state_nxt = state;
    granted   = 1'b0;
    case (item.command)
      dist_pkg::CMD_SAMPLE: begin
        if (!state.raw_seen) begin
          state_nxt.raw_last  = item.ignition;
          state_nxt.edge_time = item.timestamp_ms;
          state_nxt.raw_seen  = 1'b1;
        end else begin
          if (changed) begin
            state_nxt.raw_last  = item.ignition;
            state_nxt.edge_time = item.timestamp_ms;
          end
          if (!too_early && settled) begin
            if (!state.deb_known) begin
              state_nxt.deb_level     = item.ignition;
              state_nxt.deb_known     = 1'b1;
              state_nxt.start_pending = item.ignition && !state.active;
            end else if (state.deb_level != item.ignition) begin
              state_nxt.deb_level     = item.ignition;
              state_nxt.start_pending = item.ignition;
            end
          end
        end
      end
      dist_pkg::CMD_TAKE: begin
        if (state.start_pending && !state.active) begin
          state_nxt.start_pending = 1'b0;
          granted                 = 1'b1;
        end
      end
      dist_pkg::CMD_STARTED: begin
        state_nxt.active = 1'b1;
        // The session number skips zero when it wraps.
        state_nxt.session_count = (state.session_count == 32'hFFFF_FFFF) ? 32'd1
                                : state.session_count + 32'd1;
      end
      dist_pkg::CMD_STOPPED: begin
        state_nxt.active = 1'b0;
      end
      default: begin
        state_nxt = state;
      end
    endcase
  end

  assign result.start_granted  = granted;
  assign result.stable_level   = state_nxt.deb_level;
  assign result.stable_valid   = state_nxt.deb_known;
  assign result.session_active = state_nxt.active;
  assign result.session_number = state_nxt.session_count;

endmodule

[rtl/core/debounced_ignition_session_tracker_core.sv]
// ----------------------------------------------------------------------------
// debounced_ignition_session_tracker_core: ignition debouncer and session FSM
// Takes one event per request and returns one status result per request.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one event: an ignition sample with a timestamp,
//   a take-start request, mark-started or mark-stopped. out_valid/out_ready
//   carry one status result per event, in order.
//   An accepted request sits in the input register until it advances; the
//   state update and the result are then written together into the state
//   and result registers, out_valid rises with that write, and the result
//   is taken from the result register while out_ready is high.
//   Throughput is one request per cycle while the receiver takes each result;
//   the single debounce subtract and compare between the input register and
//   the result register sets it. When the receiver stalls, the result register
//   holds its value and the input register still takes one more request, after which in_ready drops.
//   A synchronous reset (rst_n low) empties both registers, returns the
//   tracker to idle with no session and no debounced level, and sets the
//   settle time back to 500 ms. The APB port at address 0 holds the settle
//   time; write it only while no request is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module debounced_ignition_session_tracker_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dist_pkg::dist_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dist_pkg::dist_out_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic                  s1_valid_r;
  dist_pkg::dist_in_t    s1_item_r;
  logic                  out_valid_r;
  dist_pkg::dist_out_t   out_data_r;
  dist_pkg::dist_state_t state_r;
  dist_pkg::dist_state_t state_nxt;
  dist_pkg::dist_out_t   result;
  logic [15:0]           settle_ms_r;
  logic                  advance;
  logic                  cfg_wr;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == dist_pkg::REG_SETTLE_MS) ? {16'd0, settle_ms_r} : 32'd0;

  dist_step u_step (
    .state     (state_r),
    .item      (s1_item_r),
    .settle_ms (settle_ms_r),
    .state_nxt (state_nxt),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_ms_r <= dist_pkg::SETTLE_MS_RESET;
    end else if (cfg_wr && (paddr[2] == dist_pkg::REG_SETTLE_MS)) begin
      settle_ms_r <= pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/core/dist_checker.sv]
// ----------------------------------------------------------------------------
// dist_checker: port-level checks for the session tracker
// Watches the result channel for status results that cannot occur.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dist_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input dist_pkg::dist_out_t out_data
);

  // A stalled result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A grant only happens while idle, and a take request changes only the pending start.
  a_grant_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.start_granted |-> !out_data.session_active)
    else $error("start granted while a session is active");

  a_active_numbered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.session_active |-> out_data.session_number != 32'd0)
    else $error("active session without a session number");

  a_level_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stable_level |-> out_data.stable_valid)
    else $error("stable level high before any level was accepted");

endmodule

bind debounced_ignition_session_tracker_core dist_checker u_dist_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
